// ----- rtl/core/hvn_pkg.sv -----
// ============================================================================
// hvn_pkg
// Shared constants and types for the heightmap vertex normal/tangent block.
// ============================================================================
package hvn_pkg;

    localparam int FRACTION_BITS = 14;
    localparam int HEIGHT_W      = 8;
    localparam int STEP_W        = 7;
    localparam int OUT_W         = 16;
    localparam int STEP_MIN      = 1;
    localparam int STEP_MAX      = 64;

    localparam int REL_W  = HEIGHT_W + 1;
    localparam int FACE_W = HEIGHT_W + 2;
    localparam int NUM_FACES = 6;

    // sum of six unit components stays below 8 * 2^F
    localparam int VEC_W = FRACTION_BITS + 4;
    localparam int MAG_W = VEC_W - 1;
    localparam int SQ_W  = 2 * MAG_W;
    localparam int M_W   = SQ_W + 2;
    localparam int RHS_W = SQ_W + 2 * FRACTION_BITS + 2;
    localparam int T_W   = M_W + FRACTION_BITS + 3;
    localparam int TRY_W = RHS_W + 6;
    localparam int K_W   = FRACTION_BITS + 1;

    localparam int UNIT_LAT = FRACTION_BITS + 3;
    localparam int BACK_LAT = 3 * UNIT_LAT + 2;

    localparam int QUEUE_DEPTH = 4;
    localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
    localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

    localparam logic signed [VEC_W-1:0] UNIT_ONE = VEC_W'(1) << FRACTION_BITS;

    typedef logic signed [VEC_W-1:0] vec_comp_t;
    typedef vec_comp_t vec3_t [3];

    typedef struct packed {
        logic signed [FACE_W-1:0] x;
        logic signed [FACE_W-1:0] z;
    } face_xz_t;

    typedef struct packed {
        face_xz_t [NUM_FACES-1:0] face;
        logic [STEP_W-1:0]        step;
    } face_set_t;

endpackage

// ----- rtl/core/hvn_if.sv -----
// ============================================================================
// hvn_if
// Valid/ready channel interfaces: vertex input, result output, config write.
// ============================================================================
interface hvn_vtx_if;
    import hvn_pkg::*;
    logic                valid;
    logic                ready;
    logic [HEIGHT_W-1:0] height_center;
    logic [HEIGHT_W-1:0] height_left;
    logic [HEIGHT_W-1:0] height_up;
    logic [HEIGHT_W-1:0] height_up_right;
    logic [HEIGHT_W-1:0] height_right;
    logic [HEIGHT_W-1:0] height_down;
    logic [HEIGHT_W-1:0] height_down_left;

    modport source (
        output valid, height_center, height_left, height_up, height_up_right,
               height_right, height_down, height_down_left,
        input  ready
    );
    modport sink (
        input  valid, height_center, height_left, height_up, height_up_right,
               height_right, height_down, height_down_left,
        output ready
    );
endinterface

interface hvn_res_if;
    import hvn_pkg::*;
    logic                    valid;
    logic                    ready;
    logic signed [OUT_W-1:0] normal_x;
    logic signed [OUT_W-1:0] normal_y;
    logic signed [OUT_W-1:0] normal_z;
    logic signed [OUT_W-1:0] tangent_x;
    logic signed [OUT_W-1:0] tangent_y;
    logic signed [OUT_W-1:0] tangent_z;

    modport source (
        output valid, normal_x, normal_y, normal_z, tangent_x, tangent_y, tangent_z,
        input  ready
    );
    modport sink (
        input  valid, normal_x, normal_y, normal_z, tangent_x, tangent_y, tangent_z,
        output ready
    );
endinterface

interface hvn_cfg_if;
    import hvn_pkg::*;
    logic              valid;
    logic              ready;
    logic [STEP_W-1:0] grid_step;

    modport source (output valid, grid_step, input ready);
    modport sink   (input valid, grid_step, output ready);
endinterface

// ----- rtl/core/hvn_front.sv -----
// ============================================================================
// hvn_front
// Accepts vertex items, holds grid_step, forms the six face x/z parts.
// ============================================================================
module hvn_front (
    input  logic              clk,
    input  logic              rst_n,
    hvn_vtx_if.sink           vtx,
    hvn_cfg_if.sink           cfg,
    input  logic              full,
    output logic              push,
    output hvn_pkg::face_set_t push_data
);
    import hvn_pkg::*;

    logic [STEP_W-1:0]        grid_step_reg;
    logic [STEP_W-1:0]        step_c;
    logic signed [REL_W-1:0]  rel_l, rel_u, rel_ur, rel_r, rel_d, rel_dl;
    logic signed [FACE_W-1:0] fl, fu, fur, fr, fd, fdl;

    assign cfg.ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            grid_step_reg <= STEP_W'(STEP_MIN);
        end
        else if (cfg.valid)
        begin
            grid_step_reg <= cfg.grid_step;
        end
    end

    assign vtx.ready = !full;
    assign push      = vtx.valid && !full;

    assign rel_l  = $signed({1'b0, vtx.height_left})      - $signed({1'b0, vtx.height_center});
    assign rel_u  = $signed({1'b0, vtx.height_up})        - $signed({1'b0, vtx.height_center});
    assign rel_ur = $signed({1'b0, vtx.height_up_right})  - $signed({1'b0, vtx.height_center});
    assign rel_r  = $signed({1'b0, vtx.height_right})     - $signed({1'b0, vtx.height_center});
    assign rel_d  = $signed({1'b0, vtx.height_down})      - $signed({1'b0, vtx.height_center});
    assign rel_dl = $signed({1'b0, vtx.height_down_left}) - $signed({1'b0, vtx.height_center});

    assign fl  = FACE_W'(rel_l);
    assign fu  = FACE_W'(rel_u);
    assign fur = FACE_W'(rel_ur);
    assign fr  = FACE_W'(rel_r);
    assign fd  = FACE_W'(rel_d);
    assign fdl = FACE_W'(rel_dl);

    always_comb
    begin
        if (grid_step_reg < STEP_W'(STEP_MIN))
        begin
            step_c = STEP_W'(STEP_MIN);
        end
        else if (grid_step_reg > STEP_W'(STEP_MAX))
        begin
            step_c = STEP_W'(STEP_MAX);
        end
        else
        begin
            step_c = grid_step_reg;
        end
    end

    always_comb
    begin
        push_data.step      = step_c;
        push_data.face[0].x = fl;
        push_data.face[0].z = -fu;
        push_data.face[1].x = -fr;
        push_data.face[1].z = fr - fur;
        push_data.face[2].x = -fr;
        push_data.face[2].z = fd;
        push_data.face[3].x = fdl - fd;
        push_data.face[3].z = fd;
        push_data.face[4].x = fl;
        push_data.face[4].z = fdl - fl;
        push_data.face[5].x = fu - fur;
        push_data.face[5].z = -fu;
    end

endmodule

// ----- rtl/core/hvn_queue.sv -----
// ============================================================================
// hvn_queue
// Short FIFO of face sets between the front and the back.
// ============================================================================
module hvn_queue (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               push,
    input  hvn_pkg::face_set_t push_data,
    output logic               full,
    input  logic               pop,
    output logic               empty,
    output hvn_pkg::face_set_t head
);
    import hvn_pkg::*;

    face_set_t          mem_reg [QUEUE_DEPTH];
    logic [QPTR_W-1:0]  wr_ptr_reg, rd_ptr_reg;
    logic [QCNT_W-1:0]  count_reg;

    assign full  = (count_reg == QCNT_W'(QUEUE_DEPTH));
    assign empty = (count_reg == '0);
    assign head  = mem_reg[rd_ptr_reg];

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            mem_reg[wr_ptr_reg] <= push_data;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            if (push)
            begin
                wr_ptr_reg <= wr_ptr_reg + 1'b1;
            end
            if (pop)
            begin
                rd_ptr_reg <= rd_ptr_reg + 1'b1;
            end
            count_reg <= count_reg + QCNT_W'(push) - QCNT_W'(pop);
        end
    end

endmodule

// ----- rtl/core/hvn_unit3.sv -----
// ============================================================================
// hvn_unit3
// Pipelined 3-vector normalizer: one rounded Q1.F bit per iteration stage per lane.
// ============================================================================
module hvn_unit3 (
    input  logic           clk,
    input  logic           en,
    input  hvn_pkg::vec3_t v,
    output hvn_pkg::vec3_t r,
    output logic           zero
);
    import hvn_pkg::*;

    localparam int NST = FRACTION_BITS + 2;

    logic [MAG_W-1:0]       mag_c    [3];
    logic [SQ_W-1:0]        sq_c     [3];
    logic [SQ_W-1:0]        sq_p_reg [3];
    logic                   neg_p_reg[3];
    logic [M_W-1:0]         m_c;

    logic [M_W-1:0]         m_reg   [NST];
    logic [RHS_W-1:0]       rhs_reg [NST][3];
    logic [RHS_W-1:0]       s_reg   [NST][3];
    logic signed [T_W-1:0]  t_reg   [NST][3];
    logic [K_W-1:0]         k_reg   [NST][3];
    logic                   neg_reg [NST][3];

    always_comb
    begin
        for (int i = 0; i < 3; i++)
        begin
            mag_c[i] = v[i][VEC_W-1] ? MAG_W'(-v[i]) : MAG_W'(v[i]);
            sq_c[i]  = SQ_W'(mag_c[i]) * SQ_W'(mag_c[i]);
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            for (int i = 0; i < 3; i++)
            begin
                sq_p_reg[i]  <= sq_c[i];
                neg_p_reg[i] <= v[i][VEC_W-1];
            end
        end
    end

    assign m_c = M_W'(sq_p_reg[0]) + M_W'(sq_p_reg[1]) + M_W'(sq_p_reg[2]);

    // q = 2k-1 starts at -1: S = m*q^2 = m, T = m*q = -m
    always_ff @(posedge clk)
    begin
        if (en)
        begin
            m_reg[0] <= m_c;
            for (int i = 0; i < 3; i++)
            begin
                rhs_reg[0][i] <= RHS_W'(sq_p_reg[i]) << (2 * FRACTION_BITS + 2);
                s_reg[0][i]   <= RHS_W'(m_c);
                t_reg[0][i]   <= -$signed(T_W'(m_c));
                k_reg[0][i]   <= '0;
                neg_reg[0][i] <= neg_p_reg[i];
            end
        end
    end

    for (genvar g = 1; g < NST; g++)
    begin : g_iter
        localparam int B = NST - 1 - g;

        logic [TRY_W-1:0] trial_c [3];
        logic             ok_c    [3];

        // trial (q + 2^(B+1))^2 * m from running S and T
        always_comb
        begin
            for (int i = 0; i < 3; i++)
            begin
                trial_c[i] = TRY_W'(s_reg[g-1][i])
                           + (TRY_W'(t_reg[g-1][i]) << (B + 2))
                           + (TRY_W'(m_reg[g-1]) << (2 * B + 2));
                ok_c[i]    = !k_reg[g-1][i][FRACTION_BITS]
                           && (trial_c[i] <= TRY_W'(rhs_reg[g-1][i]));
            end
        end

        always_ff @(posedge clk)
        begin
            if (en)
            begin
                m_reg[g] <= m_reg[g-1];
                for (int i = 0; i < 3; i++)
                begin
                    rhs_reg[g][i] <= rhs_reg[g-1][i];
                    neg_reg[g][i] <= neg_reg[g-1][i];
                    if (ok_c[i])
                    begin
                        k_reg[g][i] <= k_reg[g-1][i] | (K_W'(1) << B);
                        s_reg[g][i] <= RHS_W'(trial_c[i]);
                        t_reg[g][i] <= t_reg[g-1][i] + $signed(T_W'(m_reg[g-1]) << (B + 1));
                    end
                    else
                    begin
                        k_reg[g][i] <= k_reg[g-1][i];
                        s_reg[g][i] <= s_reg[g-1][i];
                        t_reg[g][i] <= t_reg[g-1][i];
                    end
                end
            end
        end
    end

    assign zero = (m_reg[NST-1] == '0);

    always_comb
    begin
        for (int i = 0; i < 3; i++)
        begin
            if (zero)
            begin
                r[i] = '0;
            end
            else if (neg_reg[NST-1][i])
            begin
                r[i] = -$signed(VEC_W'(k_reg[NST-1][i]));
            end
            else
            begin
                r[i] = $signed(VEC_W'(k_reg[NST-1][i]));
            end
        end
    end

endmodule

// ----- rtl/core/hvn_back.sv -----
// ============================================================================
// hvn_back
// Face normalization, summation, vertex normal, tangent and result register.
// ============================================================================
module hvn_back (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               empty,
    input  hvn_pkg::face_set_t head,
    output logic               pop,
    hvn_res_if.source          res
);
    import hvn_pkg::*;

    logic                    en;
    logic                    vld_reg [BACK_LAT];
    vec3_t                   face_v  [NUM_FACES];
    vec3_t                   face_u  [NUM_FACES];
    vec3_t                   sum_c, sum_reg;
    vec3_t                   nrm_u, nrm_c, tv_c, tv_reg, nrm_tv_reg, tan_u;
    vec3_t                   nrm_pipe_reg [UNIT_LAT];
    logic                    nrm_zero;
    logic [MAG_W-1:0]        ay, az;
    logic                    out_valid_reg;
    logic signed [OUT_W-1:0] nx_reg, ny_reg, nz_reg, tx_reg, ty_reg, tz_reg;

    assign en  = !out_valid_reg || res.ready;
    assign pop = en && !empty;

    always_comb
    begin
        for (int f = 0; f < NUM_FACES; f++)
        begin
            face_v[f][0] = VEC_W'(head.face[f].x);
            face_v[f][1] = $signed(VEC_W'(head.step));
            face_v[f][2] = VEC_W'(head.face[f].z);
        end
    end

    for (genvar f = 0; f < NUM_FACES; f++)
    begin : g_face
        hvn_unit3 u_face (
            .clk  (clk),
            .en   (en),
            .v    (face_v[f]),
            .r    (face_u[f]),
            .zero ()
        );
    end

    always_comb
    begin
        for (int j = 0; j < 3; j++)
        begin
            sum_c[j] = face_u[0][j] + face_u[1][j] + face_u[2][j]
                     + face_u[3][j] + face_u[4][j] + face_u[5][j];
        end
    end

    hvn_unit3 u_sum (
        .clk  (clk),
        .en   (en),
        .v    (sum_reg),
        .r    (nrm_u),
        .zero (nrm_zero)
    );

    always_comb
    begin
        if (nrm_zero)
        begin
            nrm_c[0] = '0;
            nrm_c[1] = UNIT_ONE;
            nrm_c[2] = '0;
        end
        else
        begin
            nrm_c = nrm_u;
        end
        ay = nrm_c[1][VEC_W-1] ? MAG_W'(-nrm_c[1]) : MAG_W'(nrm_c[1]);
        az = nrm_c[2][VEC_W-1] ? MAG_W'(-nrm_c[2]) : MAG_W'(nrm_c[2]);
        if (ay > az)
        begin
            tv_c[0] = nrm_c[1];
            tv_c[1] = -nrm_c[0];
            tv_c[2] = '0;
        end
        else
        begin
            tv_c[0] = -nrm_c[2];
            tv_c[1] = '0;
            tv_c[2] = nrm_c[0];
        end
    end

    hvn_unit3 u_tan (
        .clk  (clk),
        .en   (en),
        .v    (tv_reg),
        .r    (tan_u),
        .zero ()
    );

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            sum_reg         <= sum_c;
            tv_reg          <= tv_c;
            nrm_tv_reg      <= nrm_c;
            nrm_pipe_reg[0] <= nrm_tv_reg;
            for (int p = 1; p < UNIT_LAT; p++)
            begin
                nrm_pipe_reg[p] <= nrm_pipe_reg[p-1];
            end
            nx_reg <= OUT_W'(nrm_pipe_reg[UNIT_LAT-1][0]);
            ny_reg <= OUT_W'(nrm_pipe_reg[UNIT_LAT-1][1]);
            nz_reg <= OUT_W'(nrm_pipe_reg[UNIT_LAT-1][2]);
            tx_reg <= OUT_W'(tan_u[0]);
            ty_reg <= OUT_W'(tan_u[1]);
            tz_reg <= OUT_W'(tan_u[2]);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int p = 0; p < BACK_LAT; p++)
            begin
                vld_reg[p] <= 1'b0;
            end
            out_valid_reg <= 1'b0;
        end
        else if (en)
        begin
            vld_reg[0] <= !empty;
            for (int p = 1; p < BACK_LAT; p++)
            begin
                vld_reg[p] <= vld_reg[p-1];
            end
            out_valid_reg <= vld_reg[BACK_LAT-1];
        end
    end

    assign res.valid     = out_valid_reg;
    assign res.normal_x  = nx_reg;
    assign res.normal_y  = ny_reg;
    assign res.normal_z  = nz_reg;
    assign res.tangent_x = tx_reg;
    assign res.tangent_y = ty_reg;
    assign res.tangent_z = tz_reg;

endmodule

// ----- rtl/core/heightmap_vertex_normal_tangent.sv -----
// ============================================================================
// heightmap_vertex_normal_tangent
// Vertex normal and tangent from seven heightmap samples.
// ============================================================================
// Channels: vtx carries one vertex item (center height and six neighbors),
// res carries one result item (unit normal and tangent, signed Q1.14),
// cfg writes grid_step and is always ready; the user must write cfg only
// while idle, which the block does not enforce. Every vtx item produces
// exactly one res item, in order. Throughput: one item per cycle while res
// is not held. The back end is a fully pipelined chain of three normalizers
// (faces, sum, tangent), each F+3 stages with one result bit resolved per
// iteration stage, so a new item may enter every cycle unless res is held.
// Stall: while res is held, the back pipeline freezes; the 4-entry queue
// keeps taking vtx items until it fills, then vtx.ready drops.
// Reset: queue and pipeline emptied, grid_step returns to 1; no clearing
// pass, items are accepted as soon as reset is released.
// ============================================================================
module heightmap_vertex_normal_tangent (
    input  logic       clk,
    input  logic       rst_n,
    hvn_vtx_if.sink    vtx,
    hvn_cfg_if.sink    cfg,
    hvn_res_if.source  res
);
    import hvn_pkg::*;

    logic      push, pop, full, empty;
    face_set_t push_data, head;

    hvn_front u_front (
        .clk       (clk),
        .rst_n     (rst_n),
        .vtx       (vtx),
        .cfg       (cfg),
        .full      (full),
        .push      (push),
        .push_data (push_data)
    );

    hvn_queue u_queue (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (push),
        .push_data (push_data),
        .full      (full),
        .pop       (pop),
        .empty     (empty),
        .head      (head)
    );

    hvn_back u_back (
        .clk   (clk),
        .rst_n (rst_n),
        .empty (empty),
        .head  (head),
        .pop   (pop),
        .res   (res)
    );

endmodule

// ----- rtl/core/hvn_checker.sv -----
// ============================================================================
// hvn_checker
// Port-level checks on the result channel, bound to the top level.
// ============================================================================
module hvn_checker (
    input logic               clk,
    input logic               rst_n,
    input logic               res_valid,
    input logic               res_ready,
    input logic signed [15:0] normal_x,
    input logic signed [15:0] normal_y,
    input logic signed [15:0] normal_z,
    input logic signed [15:0] tangent_x,
    input logic signed [15:0] tangent_y,
    input logic signed [15:0] tangent_z
);
    import hvn_pkg::*;

    localparam logic signed [15:0] LIM = 16'sd1 <<< FRACTION_BITS;

    a_hold: assert property (@(posedge clk) disable iff (!rst_n)
        res_valid && !res_ready |=> res_valid && $stable(normal_x)
            && $stable(normal_y) && $stable(normal_z) && $stable(tangent_x))
        else $error("result changed while stalled");

    a_nrm_nonzero: assert property (@(posedge clk) disable iff (!rst_n)
        res_valid |-> (normal_x != 0 || normal_y != 0 || normal_z != 0))
        else $error("zero normal");

    a_nrm_range: assert property (@(posedge clk) disable iff (!rst_n)
        res_valid |-> (normal_y <= LIM && normal_y >= -LIM
            && normal_x <= LIM && normal_x >= -LIM))
        else $error("normal out of range");

    a_tan_axis: assert property (@(posedge clk) disable iff (!rst_n)
        res_valid |-> (tangent_y == 0 || tangent_z == 0))
        else $error("tangent not perpendicular to a basis axis");

endmodule

bind heightmap_vertex_normal_tangent hvn_checker u_hvn_checker (
    .clk       (clk),
    .rst_n     (rst_n),
    .res_valid (res.valid),
    .res_ready (res.ready),
    .normal_x  (res.normal_x),
    .normal_y  (res.normal_y),
    .normal_z  (res.normal_z),
    .tangent_x (res.tangent_x),
    .tangent_y (res.tangent_y),
    .tangent_z (res.tangent_z)
);

// ----- bench/tb_heightmap_vertex_normal_tangent.sv -----
// ============================================================================
// tb_heightmap_vertex_normal_tangent
// Drives vertex items with random idling on both sides, rewrites grid_step
// between phases while idle, and checks every result against a typed value
// or an in-bench fixed-point predictor of the face-normal average and tangent.
// ============================================================================
`timescale 1ns / 1ps

module tb_heightmap_vertex_normal_tangent;
    import hvn_pkg::*;

    localparam int RANDOM_ITEMS = 1130;
    localparam int WATCHDOG_LIMIT = 20000;
    localparam int DRAIN_CYCLES = 120;

    typedef struct {
        logic [7:0] hc, hl, hu, hur, hr, hd, hdl;
    } vertex_t;

    typedef struct packed {
        logic signed [15:0] nx, ny, nz, tx, ty, tz;
    } shading_t;

    typedef struct {
        vertex_t  v;
        logic     typed;
        shading_t exp_val;
    } stim_row_t;

    logic clk;
    logic rst_n;

    hvn_vtx_if vtx ();
    hvn_res_if res ();
    hvn_cfg_if cfg ();

    heightmap_vertex_normal_tangent i_dut (
        .clk   (clk),
        .rst_n (rst_n),
        .vtx   (vtx),
        .cfg   (cfg),
        .res   (res)
    );

    int unsigned step_model;
    shading_t    shading_q[$];
    int          mismatches;
    int          watchdog;
    bit          quiet_phase;

    initial clk = 1'b0;
    always #5 clk = ~clk;

    // round(num * 2^F / sqrt(m)), half away from zero
    function automatic longint unsigned unit_mag(longint unsigned num, longint unsigned m);
        logic [127:0]    rhs;
        logic [127:0]    lhs;
        longint unsigned lo;
        longint unsigned hi;
        longint unsigned mid;
        longint unsigned odd;
        rhs = 128'(num * num) << (2 * FRACTION_BITS + 2);
        lo = 0;
        hi = 64'd1 << FRACTION_BITS;
        while (lo < hi)
        begin
            mid = (lo + hi + 1) >> 1;
            odd = 2 * mid - 1;
            lhs = 128'(m) * 128'(odd * odd);
            if (lhs <= rhs)
                lo = mid;
            else
                hi = mid - 1;
        end
        return lo;
    endfunction

    function automatic bit normalize(input longint v[3], output longint r[3]);
        longint unsigned m;
        longint unsigned a;
        longint          k;
        m = 0;
        for (int i = 0; i < 3; i++)
        begin
            a = (v[i] < 0) ? -v[i] : v[i];
            m += a * a;
        end
        if (m == 0)
        begin
            r[0] = 0; r[1] = 0; r[2] = 0;
            return 1'b0;
        end
        for (int i = 0; i < 3; i++)
        begin
            a = (v[i] < 0) ? -v[i] : v[i];
            k = longint'(unit_mag(a, m));
            r[i] = (v[i] < 0) ? -k : k;
        end
        return 1'b1;
    endfunction

    function automatic shading_t vertex_shading(vertex_t v, int unsigned step_reg);
        longint   l, u, ur, rr, d, dl, s;
        longint   face[6][3];
        longint   f[3];
        longint   fu[3];
        longint   acc[3];
        longint   n[3];
        longint   t[3];
        longint   tu[3];
        shading_t o;
        l  = longint'(v.hl)  - longint'(v.hc);
        u  = longint'(v.hu)  - longint'(v.hc);
        ur = longint'(v.hur) - longint'(v.hc);
        rr = longint'(v.hr)  - longint'(v.hc);
        d  = longint'(v.hd)  - longint'(v.hc);
        dl = longint'(v.hdl) - longint'(v.hc);
        s = longint'(step_reg);
        if (s < STEP_MIN) s = STEP_MIN;
        if (s > STEP_MAX) s = STEP_MAX;
        face[0] = '{l, s, -u};
        face[1] = '{-rr, s, rr - ur};
        face[2] = '{-rr, s, d};
        face[3] = '{dl - d, s, d};
        face[4] = '{l, s, dl - l};
        face[5] = '{u - ur, s, -u};
        acc = '{0, 0, 0};
        for (int i = 0; i < 6; i++)
        begin
            f = face[i];
            void'(normalize(f, fu));
            for (int j = 0; j < 3; j++)
                acc[j] += fu[j];
        end
        if (!normalize(acc, n))
            n = '{0, longint'(1) << FRACTION_BITS, 0};
        if (n[1] * n[1] > n[2] * n[2])
            t = '{n[1], -n[0], 0};
        else
            t = '{-n[2], 0, n[0]};
        void'(normalize(t, tu));
        o.nx = 16'(n[0]);  o.ny = 16'(n[1]);  o.nz = 16'(n[2]);
        o.tx = 16'(tu[0]); o.ty = 16'(tu[1]); o.tz = 16'(tu[2]);
        return o;
    endfunction

    function automatic vertex_t flat_vertex(logic [7:0] h);
        vertex_t v;
        v = '{h, h, h, h, h, h, h};
        return v;
    endfunction

    function automatic vertex_t random_vertex();
        vertex_t     v;
        int unsigned base;
        int unsigned spread;
        if ($urandom_range(0, 3) == 0)
        begin
            v.hc = 8'($urandom); v.hl = 8'($urandom); v.hu = 8'($urandom);
            v.hur = 8'($urandom); v.hr = 8'($urandom); v.hd = 8'($urandom);
            v.hdl = 8'($urandom);
        end
        else
        begin
            // smooth terrain: neighbors near the center
            base = $urandom_range(0, 255);
            spread = $urandom_range(0, 3) == 0 ? 40 : 6;
            v.hc = 8'(base);
            v.hl  = 8'(int'(base) + $urandom_range(0, 2 * spread) - spread);
            v.hu  = 8'(int'(base) + $urandom_range(0, 2 * spread) - spread);
            v.hur = 8'(int'(base) + $urandom_range(0, 2 * spread) - spread);
            v.hr  = 8'(int'(base) + $urandom_range(0, 2 * spread) - spread);
            v.hd  = 8'(int'(base) + $urandom_range(0, 2 * spread) - spread);
            v.hdl = 8'(int'(base) + $urandom_range(0, 2 * spread) - spread);
        end
        return v;
    endfunction

    task automatic idle_burst(input bit enable);
        if (enable && !quiet_phase && $urandom_range(0, 3) == 0)
        begin
            vtx.valid <= 1'b0;
            repeat ($urandom_range(1, 6)) @(posedge clk);
        end
    endtask

    task automatic send_vertex(vertex_t v, bit typed, shading_t typed_val);
        shading_t p;
        idle_burst(1'b1);
        p = vertex_shading(v, step_model);
        if (typed && p != typed_val)
            $display("table row disagrees with predictor: %p vs %p", typed_val, p);
        vtx.valid           <= 1'b1;
        vtx.height_center   <= v.hc;
        vtx.height_left     <= v.hl;
        vtx.height_up       <= v.hu;
        vtx.height_up_right <= v.hur;
        vtx.height_right    <= v.hr;
        vtx.height_down     <= v.hd;
        vtx.height_down_left <= v.hdl;
        do
            @(posedge clk);
        while (!vtx.ready);
        shading_q.push_back(typed ? typed_val : p);
    endtask

    task automatic wait_drained();
        vtx.valid <= 1'b0;
        while (shading_q.size() != 0)
            @(posedge clk);
        repeat (8) @(posedge clk);
    endtask

    task automatic write_step(int unsigned value);
        wait_drained();
        cfg.valid     <= 1'b1;
        cfg.grid_step <= STEP_W'(value);
        do
            @(posedge clk);
        while (!cfg.ready);
        cfg.valid <= 1'b0;
        step_model = value & 7'h7F;
        @(posedge clk);
    endtask

    // result sink with random stalls
    initial
    begin
        res.ready = 1'b0;
        @(posedge rst_n);
        forever
        begin
            @(posedge clk);
            if (res.valid && res.ready)
            begin
                if (shading_q.size() == 0)
                begin
                    mismatches++;
                    if (mismatches <= 10)
                        $display("unexpected result item %p", res.normal_x);
                end
                else
                begin
                    shading_t e;
                    e = shading_q.pop_front();
                    if (res.normal_x !== e.nx || res.normal_y !== e.ny ||
                        res.normal_z !== e.nz || res.tangent_x !== e.tx ||
                        res.tangent_y !== e.ty || res.tangent_z !== e.tz)
                    begin
                        mismatches++;
                        if (mismatches <= 10)
                            $display("mismatch exp n=(%0d %0d %0d) t=(%0d %0d %0d) got n=(%0d %0d %0d) t=(%0d %0d %0d)",
                                     e.nx, e.ny, e.nz, e.tx, e.ty, e.tz,
                                     res.normal_x, res.normal_y, res.normal_z,
                                     res.tangent_x, res.tangent_y, res.tangent_z);
                    end
                end
            end
            if (!quiet_phase && $urandom_range(0, 5) == 0)
            begin
                res.ready <= 1'b0;
                repeat ($urandom_range(1, 6)) @(posedge clk);
                res.ready <= 1'b1;
            end
            else
                res.ready <= 1'b1;
        end
    end

    always @(posedge clk)
    begin
        if ((vtx.valid && vtx.ready) || (res.valid && res.ready) || (cfg.valid && cfg.ready))
            watchdog <= 0;
        else
            watchdog <= watchdog + 1;
    end

    initial
    begin
        stim_row_t   rows[$];
        stim_row_t   r;
        shading_t    flat;
        int unsigned steps[6];
        flat = '{16'sd0, 16'sd16384, 16'sd0, 16'sd16384, 16'sd0, 16'sd0};
        steps = '{64, 0, 127, 65, 17, 3};
        rst_n = 1'b0;
        quiet_phase = 1'b0;
        mismatches = 0;
        watchdog = 0;
        step_model = 1;
        vtx.valid = 1'b0;
        vtx.height_center = '0; vtx.height_left = '0; vtx.height_up = '0;
        vtx.height_up_right = '0; vtx.height_right = '0; vtx.height_down = '0;
        vtx.height_down_left = '0;
        cfg.valid = 1'b0;
        cfg.grid_step = '0;
        repeat (8) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        rows.push_back('{flat_vertex(8'd0), 1'b1, flat});
        rows.push_back('{flat_vertex(8'd255), 1'b1, flat});
        rows.push_back('{flat_vertex(8'd128), 1'b1, flat});
        rows.push_back('{'{8'd0, 8'd255, 8'd255, 8'd255, 8'd255, 8'd255, 8'd255}, 1'b0, flat});
        rows.push_back('{'{8'd255, 8'd0, 8'd0, 8'd0, 8'd0, 8'd0, 8'd0}, 1'b0, flat});
        rows.push_back('{'{8'd0, 8'd255, 8'd0, 8'd0, 8'd0, 8'd0, 8'd0}, 1'b0, flat});
        rows.push_back('{'{8'd0, 8'd0, 8'd255, 8'd0, 8'd0, 8'd0, 8'd0}, 1'b0, flat});
        rows.push_back('{'{8'd0, 8'd0, 8'd0, 8'd255, 8'd0, 8'd0, 8'd0}, 1'b0, flat});
        rows.push_back('{'{8'd0, 8'd0, 8'd0, 8'd0, 8'd255, 8'd0, 8'd0}, 1'b0, flat});
        rows.push_back('{'{8'd0, 8'd0, 8'd0, 8'd0, 8'd0, 8'd255, 8'd0}, 1'b0, flat});
        rows.push_back('{'{8'd0, 8'd0, 8'd0, 8'd0, 8'd0, 8'd0, 8'd255}, 1'b0, flat});
        rows.push_back('{'{8'd128, 8'd0, 8'd255, 8'd255, 8'd255, 8'd0, 8'd0}, 1'b0, flat});
        rows.push_back('{'{8'd128, 8'd255, 8'd0, 8'd0, 8'd0, 8'd255, 8'd255}, 1'b0, flat});
        rows.push_back('{'{8'd85, 8'd170, 8'd85, 8'd170, 8'd85, 8'd170, 8'd85}, 1'b0, flat});
        rows.push_back('{'{8'd170, 8'd85, 8'd170, 8'd85, 8'd170, 8'd85, 8'd170}, 1'b0, flat});
        rows.push_back('{'{8'd10, 8'd11, 8'd12, 8'd13, 8'd14, 8'd9, 8'd8}, 1'b0, flat});
        foreach (rows[i])
            send_vertex(rows[i].v, rows[i].typed, rows[i].exp_val);

        // pause the feed until every result is back, then walk step settings
        wait_drained();
        for (int p = 0; p < 6; p++)
        begin
            write_step(steps[p]);
            send_vertex('{8'd0, 8'd255, 8'd255, 8'd0, 8'd0, 8'd255, 8'd0}, 1'b0, flat);
            send_vertex(flat_vertex(8'd77), 1'b1, flat);
            for (int i = 0; i < RANDOM_ITEMS / 7; i++)
            begin
                if (p == 5 && i > RANDOM_ITEMS / 14)
                    quiet_phase = 1'b1;
                send_vertex(random_vertex(), 1'b0, flat);
            end
        end
        write_step(1);
        repeat (RANDOM_ITEMS / 7)
            send_vertex(random_vertex(), 1'b0, flat);

        wait_drained();
        repeat (DRAIN_CYCLES) @(posedge clk);
        if (mismatches == 0 && shading_q.size() == 0)
            $display("Regression PASS");
        else
            $display("Regression FAIL");
        $finish;
    end

    initial
    begin
        wait (watchdog >= WATCHDOG_LIMIT);
        $display("Regression FAIL");
        $finish;
    end

endmodule

// ----- heightmap_vertex_normal_tangent.f -----
rtl/core/hvn_pkg.sv
rtl/core/hvn_if.sv
rtl/core/hvn_front.sv
rtl/core/hvn_queue.sv
rtl/core/hvn_unit3.sv
rtl/core/hvn_back.sv
rtl/core/heightmap_vertex_normal_tangent.sv
rtl/core/hvn_checker.sv
bench/tb_heightmap_vertex_normal_tangent.sv
